/* rtl/frame_mean_window_mapper_top_assert.svh */
// Assertion macros shared by the checker file.
`ifndef FRAME_MEAN_WINDOW_MAPPER_TOP_ASSERT_SVH
`define FRAME_MEAN_WINDOW_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FMWM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FMWM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/fmwm_pkg.sv */
// ----------------------------------------------------------------------------
// fmwm_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package fmwm_pkg;

	localparam int MAX_PIXELS  = 32768;
	localparam int ADDR_W      = $clog2(MAX_PIXELS);
	localparam int CNT_W       = 16;
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = 32;
	localparam int MEAN_W      = 25;
	localparam int PIX_W       = 8;
	localparam int DIV_W       = 40;
	localparam int DIV_CNT_W   = $clog2(DIV_W);
	localparam int WINDOW_HALF = 30;
	localparam int PIX_MAX     = 255;
	localparam int FRAC_BITS   = 8;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic push;
		logic rd;
		logic div_load;
		logic div_step;
		logic div_finish;
		logic out_load;
	} fmwm_cmd_t;

	typedef struct packed {
		logic frame_ready;
		logic push_last;
		logic out_free;
	} fmwm_status_t;

endpackage

`default_nettype wire

/* rtl/fmwm_ram.sv */
// ----------------------------------------------------------------------------
// fmwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/fmwm_ctrl.sv */
// ----------------------------------------------------------------------------
// fmwm_ctrl
// Sequencer: push/read dispatch, mean division steps, readout handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module fmwm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  operation,
	input  wire fmwm_pkg::fmwm_status_t status,
	output fmwm_pkg::fmwm_cmd_t        cmd,
	output logic                       idle
);
	import fmwm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_RD
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == OP_PUSH) begin
						cmd.push = 1'b1;
					end else if (status.frame_ready) begin
						cmd.rd = 1'b1;
					end
				end
			end
			ST_PREP: cmd.div_load   = 1'b1;
			ST_DIV:  cmd.div_step   = 1'b1;
			ST_FIN:  cmd.div_finish = 1'b1;
			ST_RD:   cmd.out_load   = status.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.push && status.push_last) begin
						state_q <= ST_PREP;
					end else if (cmd.rd) begin
						state_q <= ST_RD;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_IDLE;
				ST_RD: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/fmwm_dp.sv */
// ----------------------------------------------------------------------------
// fmwm_dp
// Datapath: frame store, sum and counters, serial mean divider, pixel map,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmwm_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire fmwm_pkg::fmwm_cmd_t                  cmd,
	output fmwm_pkg::fmwm_status_t                    status,
	input  wire logic signed [fmwm_pkg::SAMPLE_W-1:0] sample_value,
	input  wire logic                                 cfg_we,
	input  wire logic        [fmwm_pkg::CNT_W-1:0]    cfg_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic             [fmwm_pkg::PIX_W-1:0]    mapped_pixel,
	output logic                                      last_pixel
);
	import fmwm_pkg::*;

	localparam int DEN_W = CNT_W + 1;
	localparam int NUM_W = DIV_W + 1;
	localparam int MAP_W = 32;

	logic [CNT_W-1:0]        frame_pixels_q;
	logic [CNT_W-1:0]        wc_q;
	logic [SUM_W-1:0]        sum_q;
	logic [MEAN_W-1:0]       mean_q;
	logic [CNT_W-1:0]        rp_q;
	logic                    ready_q;
	logic                    rd_last_q;
	logic [DIV_W-1:0]        div_num_q;
	logic [DEN_W-1:0]        div_rem_q;
	logic [DEN_W-1:0]        div_den_q;
	logic                    div_neg_q;
	logic                    out_valid_q;
	logic [PIX_W-1:0]        pix_q;
	logic                    last_q;

	logic [CNT_W-1:0]        frame_len;
	logic [CNT_W-1:0]        base_wc;
	logic [CNT_W-1:0]        next_wc;
	logic [SUM_W-1:0]        base_sum;
	logic [SAMPLE_W-1:0]     ram_rdata;
	logic [NUM_W-1:0]        num_full;
	logic [NUM_W-1:0]        num_mag;
	logic [DEN_W:0]          trial;
	logic                    trial_ge;
	logic [MEAN_W-1:0]       quo;
	logic [26:0]             map_d;
	logic [MAP_W-1:0]        map_t;
	logic [MAP_W-1:0]        map_r;
	logic [PIX_W-1:0]        map_pix;

	always_comb begin
		if (frame_pixels_q == '0) begin
			frame_len = CNT_W'(1);
		end else if ({1'b0, frame_pixels_q} > (CNT_W + 1)'(MAX_PIXELS)) begin
			frame_len = CNT_W'(MAX_PIXELS);
		end else begin
			frame_len = frame_pixels_q;
		end
	end

	assign base_wc  = ready_q ? '0 : wc_q;
	assign base_sum = ready_q ? '0 : sum_q;
	assign next_wc  = base_wc + 1'b1;

	assign status.frame_ready = ready_q;
	assign status.push_last   = (next_wc >= frame_len);
	assign status.out_free    = !out_valid_q || !out_stall;

	fmwm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (base_wc[ADDR_W-1:0]),
		.wdata (sample_value),
		.re    (cmd.rd),
		.raddr (rp_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Dividend sum*512 + n, divisor 2n: mean with round half up.
	assign num_full = {sum_q, 9'd0}
		+ {{(NUM_W - CNT_W){1'b0}}, wc_q};
	assign num_mag  = num_full[NUM_W-1] ? (~num_full + 1'b1) : num_full;
	assign trial    = {div_rem_q, div_num_q[DIV_W-1]};
	assign trial_ge = (trial >= {1'b0, div_den_q});
	assign quo      = div_num_q[MEAN_W-1:0];

	always_comb begin
		map_d = {{3{ram_rdata[SAMPLE_W-1]}}, ram_rdata, 8'd0}
			- {{2{mean_q[MEAN_W-1]}}, mean_q}
			+ 27'(WINDOW_HALF << FRAC_BITS);
		map_t = ({{(MAP_W - 27){map_d[26]}}, map_d} << 4)
			+ {{(MAP_W - 27){map_d[26]}}, map_d};
		map_r = (map_t + MAP_W'(512)) >> 10;
		if (map_t[MAP_W-1] || map_t == '0) begin
			map_pix = '0;
		end else if (map_r > MAP_W'(PIX_MAX)) begin
			map_pix = PIX_W'(PIX_MAX);
		end else begin
			map_pix = map_r[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= CNT_W'(19200);
			wc_q           <= '0;
			sum_q          <= '0;
			mean_q         <= '0;
			rp_q           <= '0;
			ready_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_pixels_q <= cfg_data;
			end
			if (cmd.push) begin
				wc_q    <= next_wc;
				sum_q   <= base_sum + {{(SUM_W - SAMPLE_W){sample_value[SAMPLE_W-1]}},
					sample_value};
				ready_q <= 1'b0;
				rp_q    <= '0;
			end
			if (cmd.rd) begin
				rp_q <= ({1'b0, rp_q} + 1'b1 >= {1'b0, wc_q}) ? '0 : rp_q + 1'b1;
			end
			if (cmd.div_finish) begin
				mean_q  <= div_neg_q ? ~(quo + MEAN_W'(div_rem_q != '0)) + 1'b1 : quo;
				ready_q <= 1'b1;
				rp_q    <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_last_q <= ({1'b0, rp_q} + 1'b1 >= {1'b0, wc_q});
		end
		if (cmd.div_load) begin
			div_num_q <= num_mag[DIV_W-1:0];
			div_rem_q <= '0;
			div_den_q <= {wc_q, 1'b0};
			div_neg_q <= num_full[NUM_W-1];
		end else if (cmd.div_step) begin
			div_rem_q <= trial_ge ? DEN_W'(trial - {1'b0, div_den_q}) : trial[DEN_W-1:0];
			div_num_q <= {div_num_q[DIV_W-2:0], trial_ge};
		end
		if (cmd.out_load) begin
			pix_q  <= map_pix;
			last_q <= rd_last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mapped_pixel = pix_q;
	assign last_pixel   = last_q;

endmodule

`default_nettype wire

/* rtl/frame_mean_window_mapper_top.sv */
// ----------------------------------------------------------------------------
// frame_mean_window_mapper_top
// Thermal frame auto-contrast: stores a frame, forms its mean, and maps
// each stored sample into an 8-bit window of mean +/- 30.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   operation, sample_value
//   out      source     out_valid / out_stall mapped_pixel, last_pixel
//   cfg      sink       cfg_valid / cfg_ready cfg_data (frame_pixels)
//
// A push is taken from idle; the push that completes a frame also runs
// the bit-serial mean divider (load, 40 quotient steps, finish).
// A read of a ready frame goes through the read state (frame store
// registered read port); a read with no ready frame gives no transfer.
// The output register holds a pixel under out_stall; pushes go on meanwhile,
// and a read waits in the sequencer until the output register is free.
// Reset clears control and accumulator state; frame store contents are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_mean_window_mapper_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 operation,
	input  wire logic signed [fmwm_pkg::SAMPLE_W-1:0] sample_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic             [fmwm_pkg::PIX_W-1:0]    mapped_pixel,
	output logic                                      last_pixel,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic        [fmwm_pkg::CNT_W-1:0]    cfg_data
);
	import fmwm_pkg::*;

	fmwm_cmd_t    cmd;
	fmwm_status_t status;
	logic         idle;

	assign in_stall  = !idle;
	assign cfg_ready = idle;

	fmwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.idle      (idle)
	);

	fmwm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_value (sample_value),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mapped_pixel (mapped_pixel),
		.last_pixel   (last_pixel)
	);

endmodule

`default_nettype wire

/* rtl/fmwm_checker.sv */
// ----------------------------------------------------------------------------
// fmwm_checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_mean_window_mapper_top_assert.svh"

module fmwm_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_stall,
	input  wire logic                                 operation,
	input  wire logic signed [fmwm_pkg::SAMPLE_W-1:0] sample_value,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_stall,
	input  wire logic        [fmwm_pkg::PIX_W-1:0]    mapped_pixel,
	input  wire logic                                 last_pixel,
	input  wire logic                                 cfg_valid,
	input  wire logic                                 cfg_ready,
	input  wire logic        [fmwm_pkg::CNT_W-1:0]    cfg_data
);
	import fmwm_pkg::*;

	logic unused_ok;
	assign unused_ok = ^{sample_value, cfg_valid, cfg_data};

	// A stalled result holds.
	`FMWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(mapped_pixel) && $stable(last_pixel))

	// Configuration is open exactly when the input side is.
	`FMWM_ASSERT_NOW(a_cfg_idle, 1'b1, cfg_ready == !in_stall)

	// A push never creates a result transfer.
	`FMWM_ASSERT_NEXT(a_push_no_out,
		in_valid && !in_stall && operation == OP_PUSH && !out_valid, !out_valid)

	// A new result only follows a stall cycle of the read handoff.
	`FMWM_ASSERT_NEXT(a_out_after_rd, !out_valid && !in_stall, !out_valid)

endmodule

bind frame_mean_window_mapper_top fmwm_checker u_chk (.*);

`default_nettype wire
